/* rtl/core/mq_arithmetic_bit_decoder_defines.svh */
// Assertion macros shared by the decoder RTL.
`ifndef MQ_ARITHMETIC_BIT_DECODER_DEFINES_SVH
`define MQ_ARITHMETIC_BIT_DECODER_DEFINES_SVH
`ifndef ASSERT_OFF
`define MQD_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mqd assertion failed");
`define MQD_ASSERT_IMP(name, ante, cons) \
  `MQD_ASSERT(name, (ante) |-> (cons))
`else
`define MQD_ASSERT(name, prop)
`define MQD_ASSERT_IMP(name, ante, cons)
`endif
`endif

/* rtl/core/mqd_pkg.sv */
`default_nettype none
package mqd_pkg;
  localparam int CONTEXT_BITS = 16;
  localparam int FIFO_DEPTH   = 8;
  localparam int PTR_W        = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W        = $clog2(FIFO_DEPTH + 1);
  localparam int CTX_W        = 7;
  localparam int QE_LAST      = 46;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_START = 2'd1,
    CMD_DEC   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic        final_byte;
    logic [15:0] context_index;
  } in_t;

  typedef struct packed {
    logic       decoded_bit;
    logic       complete;
    logic       underflow;
    logic [3:0] buffer_level;
  } out_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_START_BI, S_START_END, S_DECIDE, S_RENORM, S_FINISH
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE, OP_START, OP_BYTEIN, OP_START_END, OP_DECIDE, OP_RENORM, OP_CLEAR
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
    logic   out_load;
  } ctrl_t;

  typedef struct packed {
    logic fast_mps;
    logic renorm_last;
    logic clr_last;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [15:0] qe;
    logic [5:0]  nmps;
    logic [5:0]  nlps;
    logic        sw;
  } qe_row_t;

  function automatic qe_row_t qe_lookup(input logic [5:0] st);
    qe_row_t r;
    case (st)
      6'd0:  r = '{16'h5601, 6'd1, 6'd1, 1'b1};
      6'd1:  r = '{16'h3401, 6'd2, 6'd6, 1'b0};
      6'd2:  r = '{16'h1801, 6'd3, 6'd9, 1'b0};
      6'd3:  r = '{16'h0AC1, 6'd4, 6'd12, 1'b0};
      6'd4:  r = '{16'h0521, 6'd5, 6'd29, 1'b0};
      6'd5:  r = '{16'h0221, 6'd38, 6'd33, 1'b0};
      6'd6:  r = '{16'h5601, 6'd7, 6'd6, 1'b1};
      6'd7:  r = '{16'h5401, 6'd8, 6'd14, 1'b0};
      6'd8:  r = '{16'h4801, 6'd9, 6'd14, 1'b0};
      6'd9:  r = '{16'h3801, 6'd10, 6'd14, 1'b0};
      6'd10: r = '{16'h3001, 6'd11, 6'd17, 1'b0};
      6'd11: r = '{16'h2401, 6'd12, 6'd18, 1'b0};
      6'd12: r = '{16'h1C01, 6'd13, 6'd20, 1'b0};
      6'd13: r = '{16'h1601, 6'd29, 6'd21, 1'b0};
      6'd14: r = '{16'h5601, 6'd15, 6'd14, 1'b1};
      6'd15: r = '{16'h5401, 6'd16, 6'd14, 1'b0};
      6'd16: r = '{16'h5101, 6'd17, 6'd15, 1'b0};
      6'd17: r = '{16'h4801, 6'd18, 6'd16, 1'b0};
      6'd18: r = '{16'h3801, 6'd19, 6'd17, 1'b0};
      6'd19: r = '{16'h3401, 6'd20, 6'd18, 1'b0};
      6'd20: r = '{16'h3001, 6'd21, 6'd19, 1'b0};
      6'd21: r = '{16'h2801, 6'd22, 6'd19, 1'b0};
      6'd22: r = '{16'h2401, 6'd23, 6'd20, 1'b0};
      6'd23: r = '{16'h2201, 6'd24, 6'd21, 1'b0};
      6'd24: r = '{16'h1C01, 6'd25, 6'd22, 1'b0};
      6'd25: r = '{16'h1801, 6'd26, 6'd23, 1'b0};
      6'd26: r = '{16'h1601, 6'd27, 6'd24, 1'b0};
      6'd27: r = '{16'h1401, 6'd28, 6'd25, 1'b0};
      6'd28: r = '{16'h1201, 6'd29, 6'd26, 1'b0};
      6'd29: r = '{16'h1101, 6'd30, 6'd27, 1'b0};
      6'd30: r = '{16'h0AC1, 6'd31, 6'd28, 1'b0};
      6'd31: r = '{16'h09C1, 6'd32, 6'd29, 1'b0};
      6'd32: r = '{16'h08A1, 6'd33, 6'd30, 1'b0};
      6'd33: r = '{16'h0521, 6'd34, 6'd31, 1'b0};
      6'd34: r = '{16'h0441, 6'd35, 6'd32, 1'b0};
      6'd35: r = '{16'h02A1, 6'd36, 6'd33, 1'b0};
      6'd36: r = '{16'h0221, 6'd37, 6'd34, 1'b0};
      6'd37: r = '{16'h0141, 6'd38, 6'd35, 1'b0};
      6'd38: r = '{16'h0111, 6'd39, 6'd36, 1'b0};
      6'd39: r = '{16'h0085, 6'd40, 6'd37, 1'b0};
      6'd40: r = '{16'h0049, 6'd41, 6'd38, 1'b0};
      6'd41: r = '{16'h0025, 6'd42, 6'd39, 1'b0};
      6'd42: r = '{16'h0015, 6'd43, 6'd40, 1'b0};
      6'd43: r = '{16'h0009, 6'd44, 6'd41, 1'b0};
      6'd44: r = '{16'h0005, 6'd45, 6'd42, 1'b0};
      6'd45: r = '{16'h0001, 6'd45, 6'd43, 1'b0};
      default: r = '{16'h5601, 6'd46, 6'd46, 1'b0};
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/mqd_ctx_ram.sv */
`default_nettype none
module mqd_ctx_ram #(
  parameter int WIDTH     = 7,
  parameter int ADDR_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [ADDR_BITS-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]     wdata_i,
  input  wire logic                 re_i,
  input  wire logic [ADDR_BITS-1:0] raddr_i,
  output logic      [WIDTH-1:0]     rdata_o
);
  logic [WIDTH-1:0] mem_q [2**ADDR_BITS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

/* rtl/core/mqd_ctrl.sv */
`default_nettype none
`include "mq_arithmetic_bit_decoder_defines.svh"
module mqd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [1:0]      in_cmd_i,
  output logic                 in_stall_o,
  input  wire mqd_pkg::status_t status_i,
  output mqd_pkg::ctrl_t        ctrl_o
);
  import mqd_pkg::*;

  state_e state_q, state_d;
  logic   clr_cmd_q, clr_cmd_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_cmd_d = clr_cmd_q;
    case (state_q)
      S_CLEAR: begin
        if (status_i.clr_last) begin
          state_d = clr_cmd_q ? S_FINISH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(in_cmd_i))
            CMD_PUSH:  state_d = S_FINISH;
            CMD_START: state_d = S_START;
            CMD_DEC:   state_d = S_DECIDE;
            default: begin
              state_d   = S_CLEAR;
              clr_cmd_d = 1'b1;
            end
          endcase
        end
      end
      S_START:     state_d = S_START_BI;
      S_START_BI:  state_d = S_START_END;
      S_START_END: state_d = S_FINISH;
      S_DECIDE:    state_d = status_i.fast_mps ? S_FINISH : S_RENORM;
      S_RENORM: begin
        if (status_i.renorm_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          state_d   = S_IDLE;
          clr_cmd_d = 1'b0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.accept   = accept;
    ctrl_o.op       = OP_NONE;
    ctrl_o.out_load = 1'b0;
    case (state_q)
      S_CLEAR:     ctrl_o.op = OP_CLEAR;
      S_START:     ctrl_o.op = OP_START;
      S_START_BI:  ctrl_o.op = OP_BYTEIN;
      S_START_END: ctrl_o.op = OP_START_END;
      S_DECIDE:    ctrl_o.op = OP_DECIDE;
      S_RENORM:    ctrl_o.op = OP_RENORM;
      S_FINISH:    ctrl_o.out_load = status_i.out_free;
      default:     ctrl_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cmd_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cmd_q <= clr_cmd_d;
    end
  end

  `MQD_ASSERT(a_accept_leaves_idle, accept |=> (state_q != S_IDLE))
  `MQD_ASSERT_IMP(a_renorm_from_decide, (state_q == S_RENORM) && !$past(state_q == S_RENORM),
                  $past(state_q == S_DECIDE))
  `MQD_ASSERT_IMP(a_idle_no_clear_cmd, state_q == S_IDLE, !clr_cmd_q)
endmodule
`default_nettype wire

/* rtl/core/mqd_datapath.sv */
`default_nettype none
`include "mq_arithmetic_bit_decoder_defines.svh"
module mqd_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mqd_pkg::in_t  in_data_i,
  input  wire mqd_pkg::ctrl_t ctrl_i,
  output mqd_pkg::status_t   status_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output mqd_pkg::out_t      out_data_o
);
  import mqd_pkg::*;

  logic [15:0] a_q, a_d;
  logic [31:0] c_q, c_d;
  logic [3:0]  ct_q, ct_d;
  logic [7:0]  lbr_q, lbr_d;
  logic [1:0]  phase_q, phase_d;
  logic        done_q, done_d;
  logic [7:0]  fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic        endm_q, endm_d;
  logic        valid_q, valid_d;
  logic        under_q, under_d;
  logic        bit_q, bit_d;
  logic [CONTEXT_BITS-1:0] ctx_q;
  logic [CONTEXT_BITS-1:0] clr_q;
  logic        out_valid_q;
  out_t        out_q;

  // byte_in results
  logic [31:0] bi_c;
  logic [3:0]  bi_ct;
  logic [7:0]  bi_lbr;
  logic [1:0]  bi_phase;
  logic        bi_done, bi_valid, bi_under;
  logic [PTR_W-1:0] bi_head;
  logic [CNT_W-1:0] bi_count;

  logic        avail, miss;
  logic [7:0]  hb;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W:0]   tail_sum;
  logic [PTR_W-1:0] tail;
  logic        push_ok;

  logic [CTX_W-1:0] ram_rdata, ram_wdata;
  logic        ram_we;
  logic [CONTEXT_BITS-1:0] ram_waddr;
  logic [5:0]  st_raw, st_sat, st_new;
  logic        mps, mps_new, take_lps, c_lt;
  qe_row_t     row;
  logic [15:0] a_sub;

  assign avail    = (count_q != '0);
  assign miss     = !avail && !endm_q;
  assign hb       = avail ? fifo_q[head_q] : 8'hff;
  assign head_inc = (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
  assign tail_sum = {1'b0, head_q} + (PTR_W + 1)'(count_q);
  assign tail     = (tail_sum >= (PTR_W + 1)'(FIFO_DEPTH)) ?
                    PTR_W'(tail_sum - (PTR_W + 1)'(FIFO_DEPTH)) : PTR_W'(tail_sum);
  assign push_ok  = !endm_q && (count_q < CNT_W'(FIFO_DEPTH));

  // Byte input step, including marker detection and end of data.
  always_comb begin
    logic do_adv;
    do_adv   = 1'b0;
    bi_c     = c_q;
    bi_ct    = ct_q;
    bi_lbr   = lbr_q;
    bi_phase = phase_q;
    bi_done  = done_q;
    bi_valid = valid_q;
    bi_under = under_q;
    bi_head  = head_q;
    bi_count = count_q;
    if (lbr_q == 8'hff) begin
      bi_under = under_q | miss;
      if (hb > 8'h8f) begin
        bi_ct = 4'd8;
        case (phase_q)
          2'd0:    bi_phase = 2'd1;
          2'd1:    bi_phase = 2'd2;
          default: bi_done  = 1'b1;
        endcase
      end else begin
        do_adv = 1'b1;
        bi_c   = c_q + 32'h0000fe00 - {15'd0, hb, 9'd0};
        bi_ct  = 4'd7;
      end
    end else begin
      do_adv = 1'b1;
      bi_c   = c_q + 32'h0000ff00 - {16'd0, hb, 8'd0};
      bi_ct  = 4'd8;
    end
    if (do_adv) begin
      bi_lbr   = hb;
      bi_under = under_q | miss;
      if (avail) begin
        bi_head  = head_inc;
        bi_count = count_q - CNT_W'(1);
        bi_valid = 1'b1;
      end else if (endm_q) begin
        bi_valid = 1'b0;
      end
    end
    if (!bi_valid) begin
      bi_done = 1'b1;
    end
  end

  // Decision on the context fetched from the store.
  assign st_raw = ram_rdata[6:1];
  assign mps    = ram_rdata[0];
  assign st_sat = (st_raw > 6'(QE_LAST)) ? 6'(QE_LAST) : st_raw;
  assign row    = qe_lookup(st_sat);
  assign a_sub  = a_q - row.qe;
  assign c_lt   = (c_q[31:16] < a_sub);
  assign take_lps = c_lt ? (a_sub < row.qe) : !(a_sub < row.qe);
  assign mps_new  = (take_lps && row.sw) ? !mps : mps;
  assign st_new   = take_lps ? row.nlps : row.nmps;

  always_comb begin
    a_d = a_q; c_d = c_q; ct_d = ct_q; lbr_d = lbr_q; phase_d = phase_q;
    done_d = done_q; head_d = head_q; count_d = count_q; endm_d = endm_q;
    valid_d = valid_q; under_d = under_q; bit_d = bit_q;
    ram_we = 1'b0; ram_waddr = ctx_q; ram_wdata = {st_new, mps_new};
    if (ctrl_i.accept) begin
      under_d = 1'b0;
      bit_d   = 1'b0;
      if ((cmd_e'(in_data_i.cmd) == CMD_PUSH) && push_ok) begin
        count_d = count_q + CNT_W'(1);
        endm_d  = in_data_i.final_byte;
      end
    end
    case (ctrl_i.op)
      OP_START: begin
        phase_d = 2'd0;
        done_d  = 1'b0;
        ct_d    = 4'd0;
        lbr_d   = hb;
        under_d = under_q | miss;
        c_d     = {8'd0, hb ^ 8'hff, 16'd0};
        if (avail) begin
          head_d  = head_inc;
          count_d = count_q - CNT_W'(1);
          valid_d = 1'b1;
        end else if (endm_q) begin
          valid_d = 1'b0;
        end
      end
      OP_BYTEIN: begin
        c_d = bi_c; ct_d = bi_ct; lbr_d = bi_lbr; phase_d = bi_phase; done_d = bi_done;
        valid_d = bi_valid; under_d = bi_under; head_d = bi_head; count_d = bi_count;
      end
      OP_START_END: begin
        c_d  = {c_q[24:0], 7'd0};
        ct_d = ct_q - 4'd7;
        a_d  = 16'h8000;
      end
      OP_DECIDE: begin
        if (c_lt) begin
          a_d = a_sub;
          if (a_sub[15]) begin
            bit_d = mps;
          end else begin
            bit_d  = take_lps ? !mps : mps;
            ram_we = 1'b1;
          end
        end else begin
          c_d    = c_q - {a_sub, 16'd0};
          a_d    = row.qe;
          bit_d  = take_lps ? !mps : mps;
          ram_we = 1'b1;
        end
      end
      OP_RENORM: begin
        if (ct_q == 4'd0) begin
          lbr_d = bi_lbr; phase_d = bi_phase; done_d = bi_done; valid_d = bi_valid;
          under_d = bi_under; head_d = bi_head; count_d = bi_count;
          c_d  = {bi_c[30:0], 1'b0};
          ct_d = bi_ct - 4'd1;
        end else begin
          c_d  = {c_q[30:0], 1'b0};
          ct_d = ct_q - 4'd1;
        end
        a_d = {a_q[14:0], 1'b0};
      end
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      default: ;
    endcase
  end

  mqd_ctx_ram #(.WIDTH(CTX_W), .ADDR_BITS(CONTEXT_BITS)) u_ctx_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.accept),
    .raddr_i (in_data_i.context_index[CONTEXT_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  assign status_o.fast_mps    = c_lt && a_sub[15];
  assign status_o.renorm_last = a_q[14];
  assign status_o.clr_last    = &clr_q;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && (cmd_e'(in_data_i.cmd) == CMD_PUSH) && push_ok) begin
      fifo_q[tail] <= in_data_i.data_byte;
    end
    if (ctrl_i.accept) begin
      ctx_q <= in_data_i.context_index[CONTEXT_BITS-1:0];
    end
    if (ctrl_i.out_load) begin
      out_q.decoded_bit  <= bit_q;
      out_q.complete     <= done_q;
      out_q.underflow    <= under_q;
      out_q.buffer_level <= 4'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 16'h8000; c_q <= '0; ct_q <= '0; lbr_q <= '0; phase_q <= '0;
      done_q <= 1'b0; head_q <= '0; count_q <= '0; endm_q <= 1'b0;
      valid_q <= 1'b1; under_q <= 1'b0; bit_q <= 1'b0; clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      a_q <= a_d; c_q <= c_d; ct_q <= ct_d; lbr_q <= lbr_d; phase_q <= phase_d;
      done_q <= done_d; head_q <= head_d; count_q <= count_d; endm_q <= endm_d;
      valid_q <= valid_d; under_q <= under_d; bit_q <= bit_d;
      if (ctrl_i.op == OP_CLEAR) begin
        clr_q <= clr_q + CONTEXT_BITS'(1);
      end
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MQD_ASSERT_IMP(a_renorm_unnormalized, ctrl_i.op == OP_RENORM, !a_q[15])
  `MQD_ASSERT(a_count_bound, count_q <= CNT_W'(FIFO_DEPTH))
  `MQD_ASSERT_IMP(a_load_when_free, ctrl_i.out_load, !out_valid_q || !out_stall_i)
endmodule
`default_nettype wire

/* rtl/core/mq_arithmetic_bit_decoder.sv */
// MQ arithmetic decoder: one result transaction per input transaction.
// Push goes straight to finish; start runs start, byte-in and start-end; decode runs the
// decision, then renormalization (one shift of A and C per cycle, up to 15) if needed.
// Clear contexts sweeps all 65536 entries of the context memory, one entry a cycle.
// After reset the same sweep runs before the first input is accepted.
// Reset is asynchronous, active low; FIFO contents are undefined until written.
`default_nettype none
module mq_arithmetic_bit_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire mqd_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output mqd_pkg::out_t     out_data_o
);
  import mqd_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  mqd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  mqd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire
